FILE: rtl/scmrc_pkg.sv
// ----------------------------------------------------------------------------
// scmrc_pkg
// shared types and constants for the sync channel compensation and combiner
// ----------------------------------------------------------------------------
`default_nettype none

package scmrc_pkg;

    // subcarriers held in the combine store
    localparam int SUBCARRIERS = 62;
    localparam int SC_W        = 6;

    // q15 scaling of every product
    localparam int QSHIFT = 15;

    // output buffer depth, also the bound on items in flight
    localparam int OBUF_DEPTH = 8;
    localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
    localparam int OBUF_CW    = OBUF_AW + 1;

    // stream widths
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 72;
    localparam int ANT_W     = 2;

    // packed complex q15 value, real part in the low half
    typedef struct packed {
        logic signed [15:0] im;
        logic signed [15:0] re;
    } t_cplx;

    // one result item, subcarrier in the low bits
    typedef struct packed {
        t_cplx            comp_sec_b;
        t_cplx            comp_sec_a;
        logic [SC_W-1:0]  subcarrier_out;
    } t_out_item;

    // output buffer status
    typedef struct packed {
        logic               empty;
        logic               full;
        logic [OBUF_CW-1:0] count;
    } t_obuf_stat;

    // wrapped 16-bit part of (p >>> QSHIFT) for a 32-bit product
    function automatic logic [15:0] q15_hi32(input logic signed [31:0] p);
        q15_hi32 = p[QSHIFT +: 16];
    endfunction

    // wrapped 16-bit part of (p >>> QSHIFT) for a 33-bit product
    function automatic logic [15:0] q15_hi33(input logic signed [32:0] p);
        q15_hi33 = p[QSHIFT +: 16];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/scmrc_out_fifo.sv
// ----------------------------------------------------------------------------
// scmrc_out_fifo
// small result buffer between the compute pipeline and the output stream
// ----------------------------------------------------------------------------
`default_nettype none

module scmrc_out_fifo (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  scmrc_pkg::t_out_item    i_push_item,
    input  wire                     i_pop,
    output scmrc_pkg::t_out_item    o_head_item,
    output scmrc_pkg::t_obuf_stat   o_stat
);

    scmrc_pkg::t_out_item                r_buf [0:scmrc_pkg::OBUF_DEPTH-1];
    logic [scmrc_pkg::OBUF_AW-1:0]       r_wr_ptr;
    logic [scmrc_pkg::OBUF_AW-1:0]       r_rd_ptr;
    logic [scmrc_pkg::OBUF_CW-1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head_item  = r_buf[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == scmrc_pkg::OBUF_CW'(scmrc_pkg::OBUF_DEPTH));
    assign o_stat.count = r_count;

endmodule

`default_nettype wire

FILE: rtl/sync_channel_comp_mrc.sv
// ----------------------------------------------------------------------------
// sync_channel_comp_mrc
// sync-based channel compensation with maximum-ratio combining over antennas
// ----------------------------------------------------------------------------
// an accepted item passes the pipeline stages and the output buffer before its result is offered
// throughput: one item per cycle while an output buffer slot is free, set by the read-modify-write
//   of the combine store (one read port and one write port, both used each cycle)
// up to 8 items in flight, bounded by the output buffer depth
// reset (i_rst_n low, synchronous) clears pipeline valids, pointers and counters;
//   combine store contents are undefined until written by antenna 0
`default_nettype none

module sync_channel_comp_mrc (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input stream
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // subcarrier[5:0], sync_a_sample[37:6], sync_b_sample[69:38],
    // sec_a_sample[101:70], sec_b_sample[133:102], sync_reference[165:134], pad
    input  wire [scmrc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // antenna_index[1:0]
    input  wire [scmrc_pkg::ANT_W-1:0]        s_axis_tuser,
    // output stream
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // subcarrier_out[5:0], comp_sec_a[37:6], comp_sec_b[69:38], pad
    output logic [scmrc_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    // ------------------------------------------------------------------
    // handshake and flow control
    // every accepted item owns a slot in the output buffer until its
    // result leaves, so the pipeline itself never stalls
    // ------------------------------------------------------------------
    logic                               in_xfer;
    logic                               out_xfer;
    logic [scmrc_pkg::OBUF_CW-1:0]      r_inflight;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_inflight < scmrc_pkg::OBUF_CW'(scmrc_pkg::OBUF_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            case ({in_xfer, out_xfer})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input unpacking
    // ------------------------------------------------------------------
    scmrc_pkg::t_cplx                in_sync_a;
    scmrc_pkg::t_cplx                in_sync_b;
    scmrc_pkg::t_cplx                in_sec_a;
    scmrc_pkg::t_cplx                in_sec_b;
    scmrc_pkg::t_cplx                in_ref;
    logic [scmrc_pkg::SC_W-1:0]      in_sc;

    assign in_sc     = s_axis_tdata[5:0];
    assign in_sync_a = scmrc_pkg::t_cplx'(s_axis_tdata[37:6]);
    assign in_sync_b = scmrc_pkg::t_cplx'(s_axis_tdata[69:38]);
    assign in_sec_a  = scmrc_pkg::t_cplx'(s_axis_tdata[101:70]);
    assign in_sec_b  = scmrc_pkg::t_cplx'(s_axis_tdata[133:102]);
    assign in_ref    = scmrc_pkg::t_cplx'(s_axis_tdata[165:134]);

    // ------------------------------------------------------------------
    // stage 1: sum of the two sync samples, 17 bits, no wrap
    // ------------------------------------------------------------------
    logic                               r1_vld;
    logic [scmrc_pkg::ANT_W-1:0]        r1_ant;
    logic [scmrc_pkg::SC_W-1:0]         r1_sc;
    logic signed [16:0]                 r1_sre;
    logic signed [16:0]                 r1_sim;
    scmrc_pkg::t_cplx                   r1_ref;
    scmrc_pkg::t_cplx                   r1_xa;
    scmrc_pkg::t_cplx                   r1_xb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ant <= s_axis_tuser;
        r1_sc  <= in_sc;
        r1_sre <= 17'(in_sync_a.re) + 17'(in_sync_b.re);
        r1_sim <= 17'(in_sync_a.im) + 17'(in_sync_b.im);
        r1_ref <= in_ref;
        r1_xa  <= in_sec_a;
        r1_xb  <= in_sec_b;
    end

    // ------------------------------------------------------------------
    // stage 2: the four products of the sync sum with the reference
    // ------------------------------------------------------------------
    logic                               r2_vld;
    logic [scmrc_pkg::ANT_W-1:0]        r2_ant;
    logic [scmrc_pkg::SC_W-1:0]         r2_sc;
    logic signed [32:0]                 r2_prr;
    logic signed [32:0]                 r2_pii;
    logic signed [32:0]                 r2_pri;
    logic signed [32:0]                 r2_pir;
    scmrc_pkg::t_cplx                   r2_xa;
    scmrc_pkg::t_cplx                   r2_xb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_ant <= r1_ant;
        r2_sc  <= r1_sc;
        r2_prr <= 33'(r1_sre) * 33'(r1_ref.re);
        r2_pii <= 33'(r1_sim) * 33'(r1_ref.im);
        r2_pri <= 33'(r1_sre) * 33'(r1_ref.im);
        r2_pir <= 33'(r1_sim) * 33'(r1_ref.re);
        r2_xa  <= r1_xa;
        r2_xb  <= r1_xb;
    end

    // ------------------------------------------------------------------
    // stage 3: conjugate channel estimate h, truncated and wrapped
    // ------------------------------------------------------------------
    logic                               r3_vld;
    logic [scmrc_pkg::ANT_W-1:0]        r3_ant;
    logic [scmrc_pkg::SC_W-1:0]         r3_sc;
    scmrc_pkg::t_cplx                   r3_h;
    scmrc_pkg::t_cplx                   r3_xa;
    scmrc_pkg::t_cplx                   r3_xb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_ant  <= r2_ant;
        r3_sc   <= r2_sc;
        r3_h.re <= scmrc_pkg::q15_hi33(r2_prr) + scmrc_pkg::q15_hi33(r2_pii);
        r3_h.im <= scmrc_pkg::q15_hi33(r2_pri) - scmrc_pkg::q15_hi33(r2_pir);
        r3_xa   <= r2_xa;
        r3_xb   <= r2_xb;
    end

    // ------------------------------------------------------------------
    // stage 4: products of h with both secondary samples, store read
    // ------------------------------------------------------------------
    logic                               r4_vld;
    logic [scmrc_pkg::ANT_W-1:0]        r4_ant;
    logic [scmrc_pkg::SC_W-1:0]         r4_sc;
    logic signed [31:0]                 r4_a_rr;
    logic signed [31:0]                 r4_a_ii;
    logic signed [31:0]                 r4_a_ri;
    logic signed [31:0]                 r4_a_ir;
    logic signed [31:0]                 r4_b_rr;
    logic signed [31:0]                 r4_b_ii;
    logic signed [31:0]                 r4_b_ri;
    logic signed [31:0]                 r4_b_ir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_ant  <= r3_ant;
        r4_sc   <= r3_sc;
        r4_a_rr <= 32'(r3_h.re) * 32'(r3_xa.re);
        r4_a_ii <= 32'(r3_h.im) * 32'(r3_xa.im);
        r4_a_ri <= 32'(r3_h.re) * 32'(r3_xa.im);
        r4_a_ir <= 32'(r3_h.im) * 32'(r3_xa.re);
        r4_b_rr <= 32'(r3_h.re) * 32'(r3_xb.re);
        r4_b_ii <= 32'(r3_h.im) * 32'(r3_xb.im);
        r4_b_ri <= 32'(r3_h.re) * 32'(r3_xb.im);
        r4_b_ir <= 32'(r3_h.im) * 32'(r3_xb.re);
    end

    // ------------------------------------------------------------------
    // combine store: one entry per subcarrier, sec_a low, sec_b high
    // read in the cycle before the combine, written as the item leaves
    // ------------------------------------------------------------------
    logic [63:0]                        r_store [0:scmrc_pkg::SUBCARRIERS-1];
    logic [63:0]                        r_rd_data;
    logic                               r_fwd_hit;
    logic [63:0]                        r_fwd_data;

    logic                               rd_en;
    logic                               wr_en;
    logic [63:0]                        wr_data;
    logic                               in_range;
    logic                               do_add;
    logic [63:0]                        old_entry;
    scmrc_pkg::t_cplx                   ya;
    scmrc_pkg::t_cplx                   yb;
    scmrc_pkg::t_cplx                   old_a;
    scmrc_pkg::t_cplx                   old_b;
    scmrc_pkg::t_out_item               push_item;

    assign rd_en    = r3_vld && (r3_sc < scmrc_pkg::SC_W'(scmrc_pkg::SUBCARRIERS));
    assign in_range = (r4_sc < scmrc_pkg::SC_W'(scmrc_pkg::SUBCARRIERS));
    assign wr_en    = r4_vld && in_range;
    // antenna 0 starts a fresh sum, out-of-range items pass their own values
    assign do_add   = in_range && (r4_ant != '0);

    // the write of the item ahead lands at the same edge as this read
    assign old_entry = r_fwd_hit ? r_fwd_data : r_rd_data;
    assign old_a     = scmrc_pkg::t_cplx'(old_entry[31:0]);
    assign old_b     = scmrc_pkg::t_cplx'(old_entry[63:32]);

    always_comb begin
        ya.re = scmrc_pkg::q15_hi32(r4_a_rr) - scmrc_pkg::q15_hi32(r4_a_ii);
        ya.im = scmrc_pkg::q15_hi32(r4_a_ri) + scmrc_pkg::q15_hi32(r4_a_ir);
        yb.re = scmrc_pkg::q15_hi32(r4_b_rr) - scmrc_pkg::q15_hi32(r4_b_ii);
        yb.im = scmrc_pkg::q15_hi32(r4_b_ri) + scmrc_pkg::q15_hi32(r4_b_ir);
        if (do_add) begin
            ya.re = ya.re + old_a.re;
            ya.im = ya.im + old_a.im;
            yb.re = yb.re + old_b.re;
            yb.im = yb.im + old_b.im;
        end
    end

    assign wr_data = {yb, ya};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r4_sc] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_store[r3_sc];
        end
        r_fwd_data <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= wr_en && rd_en && (r4_sc == r3_sc);
        end
    end

    // ------------------------------------------------------------------
    // output buffer and result stream
    // ------------------------------------------------------------------
    scmrc_pkg::t_out_item               head_item;
    scmrc_pkg::t_obuf_stat              obuf_stat;

    assign push_item.subcarrier_out = r4_sc;
    assign push_item.comp_sec_a     = ya;
    assign push_item.comp_sec_b     = yb;

    scmrc_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r4_vld),
        .i_push_item (push_item),
        .i_pop       (out_xfer),
        .o_head_item (head_item),
        .o_stat      (obuf_stat)
    );

    assign m_axis_tvalid = !obuf_stat.empty;
    assign m_axis_tdata  = {2'b00, head_item};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // slot accounting never oversubscribes the output buffer
    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= scmrc_pkg::OBUF_CW'(scmrc_pkg::OBUF_DEPTH))
        else $error("items in flight exceed output buffer depth");

    // buffered results are always covered by in-flight slots
    a_buf_le_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        obuf_stat.count <= r_inflight)
        else $error("output buffer holds more than in flight");

    // a result leaving the pipeline always finds room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_vld |-> !obuf_stat.full)
        else $error("push into full output buffer");

    // forwarding only follows a store write
    a_fwd_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> $past(wr_en))
        else $error("forward hit without a preceding write");

endmodule

`default_nettype wire
